### rtl/core/wfc_pkg.sv
package wfc_pkg;

    localparam int ENTRIES    = 1024;
    localparam int MAX_WORD   = 60;
    localparam int STOP_WORDS = 64;
    localparam int HEADS      = 1024;
    localparam int WORD_CAP   = MAX_WORD - 1;

    localparam int EIDX_W  = $clog2(ENTRIES);
    localparam int ECNT_W  = EIDX_W + 1;
    localparam int HEAD_W  = EIDX_W + 1;
    localparam int HEAD_AW = $clog2(HEADS);
    localparam int SIDX_W  = $clog2(STOP_WORDS);
    localparam int SCNT_W  = SIDX_W + 1;
    localparam int LEN_W   = $clog2(MAX_WORD);
    localparam int HASH_W  = 10;
    localparam int BC_W    = 11;
    localparam int COUNT_W = 24;
    localparam int DVD_W   = HASH_W + 8;
    localparam int WC_AW   = $clog2(ENTRIES * MAX_WORD);
    localparam int SC_AW   = $clog2(STOP_WORDS * MAX_WORD);

    localparam logic [HEAD_W-1:0]  HEAD_NIL  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] OP_TEXT = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [3:0] STS_SHORT     = 4'd0;
    localparam logic [3:0] STS_STOP      = 4'd1;
    localparam logic [3:0] STS_INSERTED  = 4'd2;
    localparam logic [3:0] STS_COUNTED   = 4'd3;
    localparam logic [3:0] STS_FULL      = 4'd4;
    localparam logic [3:0] STS_STOP_LOAD = 4'd5;
    localparam logic [3:0] STS_STOP_FULL = 4'd6;
    localparam logic [3:0] STS_READ      = 4'd7;
    localparam logic [3:0] STS_INVALID   = 4'd8;

    typedef enum logic [1:0] {
        CLS_TEXT,
        CLS_STOP,
        CLS_READ,
        CLS_BAD
    } t_cls;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_HASH,
        S_STOP_END,
        S_RD_META,
        S_RD_CHK,
        S_RD_ADDR,
        S_RD_OUT,
        S_FIN,
        S_SL_RD,
        S_SL_CHK,
        S_SC_RD,
        S_SC_CHK,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_WALK,
        S_WL_CHK,
        S_WC_RD,
        S_WC_CHK,
        S_INS,
        S_CP_RD,
        S_CP_WR
    } t_state;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic       token_end;
        logic [9:0] entry_index;
    } t_item;

    typedef struct packed {
        logic [3:0]  status;
        logic [9:0]  word_index;
        logic [23:0] word_total;
        logic [7:0]  read_char;
        logic        last;
    } t_result;

    typedef struct packed {
        t_cls              cls;
        logic [7:0]        ch;
        logic              tend;
        logic [EIDX_W-1:0] ei;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_ctl;

endpackage

### rtl/core/word_frequency_counter_unit.sv
// Word frequency counter with chained hash buckets.
// Items enter through start/busy and i_item: an item is taken at a clock edge where
// start is high and busy is low. Text bytes are lowercased letters building a word;
// token_end closes it, and the word is dropped if short or a stop word, else counted
// or inserted. Stop-word bytes load the stop store; a read item returns one result
// per character of the chosen entry. i_cfg_we writes the bucket count at any edge.
// Results appear on o_result for one cycle with o_result_valid high; the receiver
// cannot stall, and the block never holds a result back.
// A two-item queue sits in front of a sequential engine, so busy rises when the queue
// is full or while the bucket heads are cleared. A text byte with a letter waits in
// the engine for the bit-serial hash remainder unit (18 steps); other bytes skip it.
// A token end compares the stored characters against each stop word of the same
// length, then reads the bucket head, walks the chain entries comparing characters,
// and on insertion copies the word into the new entry character by character. A read
// returns the characters of the chosen entry one at a time.
// After reset all 1024 bucket heads are cleared, one per cycle, with busy high; all
// counts, stop words and entries are empty and the bucket count is 1024.
module word_frequency_counter_unit
    import wfc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_item           i_item,
    input  logic            i_cfg_we,
    input  logic [BC_W-1:0] i_cfg_wdata,
    output t_result         o_result,
    output logic            o_result_valid
);

    logic [BC_W-1:0]   r_bucket_count;
    logic [BC_W-1:0]   w_modulus;
    logic              w_valid;
    t_cmd              w_cmd;
    t_back_ctl         w_ctl;
    logic              w_mod_start;
    logic [DVD_W-1:0]  w_mod_dvd;
    logic              w_mod_done;
    logic [HASH_W-1:0] w_mod_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BC_W'(HEADS);
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    assign w_modulus = (r_bucket_count == '0) ? BC_W'(1) :
                       (r_bucket_count > BC_W'(HEADS)) ? BC_W'(HEADS) : r_bucket_count;

    wfc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .i_ctl(w_ctl), .o_valid(w_valid), .o_cmd(w_cmd)
    );

    wfc_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mod_start), .i_dividend(w_mod_dvd),
        .i_divisor(w_modulus), .o_done(w_mod_done), .o_rem(w_mod_rem)
    );

    wfc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_cmd(w_cmd), .o_ctl(w_ctl),
        .o_mod_start(w_mod_start), .o_mod_dvd(w_mod_dvd),
        .i_mod_done(w_mod_done), .i_mod_rem(w_mod_rem), .o_result(o_result),
        .o_result_valid(o_result_valid)
    );

endmodule

### rtl/core/wfc_ram.sv
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/wfc_front.sv
module wfc_front
    import wfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_item     i_item,
    input  t_back_ctl i_ctl,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.ch   = i_item.char_code;
        w_cmd.tend = i_item.token_end;
        w_cmd.ei   = i_item.entry_index;
        case (i_item.operation)
            OP_TEXT: w_cmd.cls = CLS_TEXT;
            OP_STOP: w_cmd.cls = CLS_STOP;
            OP_READ: w_cmd.cls = CLS_READ;
            default: w_cmd.cls = CLS_BAD;
        endcase
    end

    assign busy    = (r_count == 2'd2) || i_ctl.clearing;
    assign w_push  = start && !busy;
    assign o_valid = (r_count != 2'd0);
    assign w_pop   = i_ctl.pop && o_valid;
    assign o_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

### rtl/core/wfc_mod.sv
module wfc_mod
    import wfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [BC_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [HASH_W-1:0] o_rem
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DVD_W-1:0]  r_dvd;
    logic [BC_W-1:0]   r_div;
    logic [BC_W-1:0]   r_rem;
    logic              r_done;
    logic [BC_W:0]     w_trial;
    logic [BC_W-1:0]   w_next;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_next  = (w_trial >= {1'b0, r_div}) ? BC_W'(w_trial - {1'b0, r_div})
                                                : BC_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_next;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[HASH_W-1:0];

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_busy |-> (r_rem < r_div))
        else $error("remainder not below divisor");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("done raised while still dividing");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) i_start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

### rtl/core/wfc_back.sv
module wfc_back
    import wfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_cmd              i_cmd,
    output t_back_ctl         o_ctl,
    output logic              o_mod_start,
    output logic [DVD_W-1:0]  o_mod_dvd,
    input  logic              i_mod_done,
    input  logic [HASH_W-1:0] i_mod_rem,
    output t_result           o_result,
    output logic              o_result_valid
);

    t_state              r_state, n_state;
    logic [HEAD_AW-1:0]  r_clr, n_clr;
    t_cmd                r_cmd, n_cmd;
    logic [LEN_W-1:0]    r_tlen, n_tlen;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [SCNT_W-1:0]   r_sused, n_sused;
    logic [LEN_W-1:0]    r_sfill, n_sfill;
    logic [ECNT_W-1:0]   r_eused, n_eused;
    logic [SCNT_W-1:0]   r_s, n_s;
    logic [LEN_W-1:0]    r_j, n_j;
    logic [HEAD_W-1:0]   r_e, n_e;
    logic [HEAD_W-1:0]   r_head, n_head;
    logic [HEAD_W-1:0]   r_next, n_next;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [COUNT_W-1:0]  r_cnt, n_cnt;
    t_result             r_res, n_res;
    logic                r_res_v, n_res_v;

    logic                tb_we;
    logic [LEN_W-1:0]    tb_waddr, tb_raddr;
    logic [7:0]          tb_wdata, tb_rdata;
    logic                sc_we;
    logic [SC_AW-1:0]    sc_waddr, sc_raddr;
    logic [7:0]          sc_rdata;
    logic                sl_we;
    logic [SIDX_W-1:0]   sl_raddr;
    logic [LEN_W-1:0]    sl_rdata;
    logic                wc_we;
    logic [WC_AW-1:0]    wc_waddr, wc_raddr;
    logic [7:0]          wc_wdata, wc_rdata;
    logic                wm_we;
    logic [EIDX_W-1:0]   wm_waddr, wm_raddr;
    logic [LEN_W-1:0]    wl_rdata;
    logic                cnt_we;
    logic [EIDX_W-1:0]   cnt_waddr;
    logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic [HEAD_W-1:0]   nx_rdata;
    logic                hd_we;
    logic [HEAD_AW-1:0]  hd_waddr;
    logic [HEAD_W-1:0]   hd_wdata, hd_rdata;

    logic [7:0]          w_letter;
    logic                w_is_letter;
    logic                w_take;
    logic                w_room;
    logic                w_sput;
    logic                w_rd_ok;
    logic                w_jlast;
    logic                w_rlast;
    logic                w_ch_eq;
    logic                w_full;
    logic [LEN_W-1:0]    w_rlen;
    logic [COUNT_W-1:0]  w_inc;
    logic [WC_AW-1:0]    w_wc_walk, w_wc_read, w_wc_ins;
    logic [SC_AW-1:0]    w_sc_cmp, w_sc_put;

    always_comb begin
        w_letter    = r_cmd.ch;
        w_is_letter = 1'b0;
        if (r_cmd.ch >= 8'h41 && r_cmd.ch <= 8'h5A) begin
            w_letter    = r_cmd.ch + 8'd32;
            w_is_letter = 1'b1;
        end else if (r_cmd.ch >= 8'h61 && r_cmd.ch <= 8'h7A) begin
            w_is_letter = 1'b1;
        end
    end

    assign w_take  = w_is_letter && (r_tlen < LEN_W'(WORD_CAP));
    assign w_room  = r_sused < SCNT_W'(STOP_WORDS);
    assign w_sput  = w_room && (r_sfill < LEN_W'(WORD_CAP));
    assign w_rd_ok = {1'b0, r_cmd.ei} < r_eused;
    assign w_jlast = ({1'b0, r_j} + (LEN_W+1)'(1)) == {1'b0, r_tlen};
    assign w_rlast = ({1'b0, r_j} + (LEN_W+1)'(1)) == {1'b0, r_len};
    assign w_full  = r_eused >= ECNT_W'(ENTRIES);
    assign w_rlen  = (wl_rdata > LEN_W'(WORD_CAP)) ? LEN_W'(WORD_CAP) : wl_rdata;
    assign w_inc   = (r_cnt == COUNT_MAX) ? r_cnt : r_cnt + 1'b1;

    assign w_wc_walk = WC_AW'(r_e[EIDX_W-1:0]) * WC_AW'(MAX_WORD) + WC_AW'(r_j);
    assign w_wc_read = WC_AW'(r_cmd.ei) * WC_AW'(MAX_WORD) + WC_AW'(r_j);
    assign w_wc_ins  = WC_AW'(r_eused[EIDX_W-1:0]) * WC_AW'(MAX_WORD) + WC_AW'(r_j);
    assign w_sc_cmp  = SC_AW'(r_s[SIDX_W-1:0]) * SC_AW'(MAX_WORD) + SC_AW'(r_j);
    assign w_sc_put  = SC_AW'(r_sused[SIDX_W-1:0]) * SC_AW'(MAX_WORD) + SC_AW'(r_sfill);
    assign w_ch_eq   = (tb_rdata == (r_state == S_SC_CHK ? sc_rdata : wc_rdata));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_clr == HEAD_AW'(HEADS - 1)) n_state = S_IDLE;
            S_IDLE:     if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                case (r_cmd.cls)
                    CLS_TEXT: begin
                        if (w_take) n_state = S_HASH;
                        else if (r_cmd.tend) n_state = S_FIN;
                        else n_state = S_IDLE;
                    end
                    CLS_STOP: n_state = r_cmd.tend ? S_STOP_END : S_IDLE;
                    CLS_READ: n_state = w_rd_ok ? S_RD_META : S_IDLE;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_HASH:     if (i_mod_done) n_state = r_cmd.tend ? S_FIN : S_IDLE;
            S_STOP_END: n_state = S_IDLE;
            S_RD_META:  n_state = S_RD_CHK;
            S_RD_CHK:   n_state = (w_rlen == '0) ? S_IDLE : S_RD_ADDR;
            S_RD_ADDR:  n_state = S_RD_OUT;
            S_RD_OUT:   n_state = w_rlast ? S_IDLE : S_RD_ADDR;
            S_FIN:      n_state = (r_tlen < LEN_W'(2)) ? S_IDLE : S_SL_RD;
            S_SL_RD:    n_state = (r_s < r_sused) ? S_SL_CHK : S_HEAD_RD;
            S_SL_CHK:   n_state = (sl_rdata == r_tlen) ? S_SC_RD : S_SL_RD;
            S_SC_RD:    n_state = S_SC_CHK;
            S_SC_CHK: begin
                if (!w_ch_eq) n_state = S_SL_RD;
                else if (w_jlast) n_state = S_IDLE;
                else n_state = S_SC_RD;
            end
            S_HEAD_RD:  n_state = S_HEAD_CHK;
            S_HEAD_CHK: n_state = S_WALK;
            S_WALK:     n_state = r_e[HEAD_W-1] ? S_INS : S_WL_CHK;
            S_WL_CHK:   n_state = (wl_rdata == r_tlen) ? S_WC_RD : S_WALK;
            S_WC_RD:    n_state = S_WC_CHK;
            S_WC_CHK: begin
                if (!w_ch_eq) n_state = S_WALK;
                else if (w_jlast) n_state = S_IDLE;
                else n_state = S_WC_RD;
            end
            S_INS:      n_state = w_full ? S_IDLE : S_CP_RD;
            S_CP_RD:    n_state = S_CP_WR;
            S_CP_WR:    n_state = w_jlast ? S_IDLE : S_CP_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_clr   = r_clr;
        n_cmd   = r_cmd;
        n_tlen  = r_tlen;
        n_hash  = r_hash;
        n_sused = r_sused;
        n_sfill = r_sfill;
        n_eused = r_eused;
        n_s     = r_s;
        n_j     = r_j;
        n_e     = r_e;
        n_head  = r_head;
        n_next  = r_next;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_res   = '0;
        n_res_v = 1'b0;

        o_ctl.clearing = (r_state == S_CLEAR);
        o_ctl.pop      = 1'b0;
        o_mod_start    = 1'b0;
        o_mod_dvd      = {r_hash, w_letter};

        tb_we     = 1'b0;
        tb_waddr  = r_tlen;
        tb_wdata  = w_letter;
        tb_raddr  = r_j;
        sc_we     = 1'b0;
        sc_waddr  = w_sc_put;
        sc_raddr  = w_sc_cmp;
        sl_we     = 1'b0;
        sl_raddr  = r_s[SIDX_W-1:0];
        wc_we     = 1'b0;
        wc_waddr  = w_wc_ins;
        wc_wdata  = tb_rdata;
        wc_raddr  = (r_state == S_RD_ADDR) ? w_wc_read : w_wc_walk;
        wm_we     = 1'b0;
        wm_waddr  = r_eused[EIDX_W-1:0];
        wm_raddr  = (r_state == S_RD_META) ? r_cmd.ei : r_e[EIDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = r_eused[EIDX_W-1:0];
        cnt_wdata = COUNT_W'(1);
        hd_we     = 1'b0;
        hd_waddr  = r_hash;
        hd_wdata  = HEAD_W'(r_eused);

        case (r_state)
            S_CLEAR: begin
                hd_we    = 1'b1;
                hd_waddr = r_clr;
                hd_wdata = HEAD_NIL;
                n_clr    = r_clr + 1'b1;
            end
            S_IDLE: begin
                o_ctl.pop = i_valid;
                n_cmd     = i_cmd;
            end
            S_EXEC: begin
                case (r_cmd.cls)
                    CLS_TEXT: begin
                        if (w_take) begin
                            tb_we       = 1'b1;
                            n_tlen      = r_tlen + 1'b1;
                            o_mod_start = 1'b1;
                        end
                    end
                    CLS_STOP: begin
                        if (w_sput) begin
                            sc_we   = 1'b1;
                            n_sfill = r_sfill + 1'b1;
                        end
                    end
                    CLS_READ: begin
                        if (!w_rd_ok) begin
                            n_res_v       = 1'b1;
                            n_res.status  = STS_INVALID;
                            n_res.last    = 1'b1;
                        end
                    end
                    default: begin
                        n_res_v      = 1'b1;
                        n_res.status = STS_INVALID;
                        n_res.last   = 1'b1;
                    end
                endcase
            end
            S_HASH: begin
                if (i_mod_done) begin
                    n_hash = i_mod_rem;
                end
            end
            S_STOP_END: begin
                n_res_v    = 1'b1;
                n_res.last = 1'b1;
                n_sfill    = '0;
                if (w_room) begin
                    sl_we        = 1'b1;
                    n_sused      = r_sused + 1'b1;
                    n_res.status = STS_STOP_LOAD;
                end else begin
                    n_res.status = STS_STOP_FULL;
                end
            end
            S_RD_CHK: begin
                n_len = w_rlen;
                n_cnt = cnt_rdata;
                n_j   = '0;
                if (w_rlen == '0) begin
                    n_res_v      = 1'b1;
                    n_res.status = STS_INVALID;
                    n_res.last   = 1'b1;
                end
            end
            S_RD_OUT: begin
                n_res_v          = 1'b1;
                n_res.status     = STS_READ;
                n_res.word_index = r_cmd.ei;
                n_res.word_total = r_cnt;
                n_res.read_char  = wc_rdata;
                n_res.last       = w_rlast;
                n_j              = r_j + 1'b1;
            end
            S_FIN: begin
                n_s = '0;
                if (r_tlen < LEN_W'(2)) begin
                    n_res_v      = 1'b1;
                    n_res.status = STS_SHORT;
                    n_res.last   = 1'b1;
                    n_tlen       = '0;
                    n_hash       = '0;
                end
            end
            S_SL_CHK: begin
                n_j = '0;
                if (sl_rdata != r_tlen) begin
                    n_s = r_s + 1'b1;
                end
            end
            S_SC_CHK: begin
                if (!w_ch_eq) begin
                    n_s = r_s + 1'b1;
                end else if (w_jlast) begin
                    n_res_v      = 1'b1;
                    n_res.status = STS_STOP;
                    n_res.last   = 1'b1;
                    n_tlen       = '0;
                    n_hash       = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_HEAD_CHK: begin
                n_head = hd_rdata;
                n_e    = hd_rdata;
            end
            S_WL_CHK: begin
                n_cnt  = cnt_rdata;
                n_next = nx_rdata;
                n_j    = '0;
                if (wl_rdata != r_tlen) begin
                    n_e = nx_rdata;
                end
            end
            S_WC_CHK: begin
                if (!w_ch_eq) begin
                    n_e = r_next;
                end else if (w_jlast) begin
                    cnt_we           = 1'b1;
                    cnt_waddr        = r_e[EIDX_W-1:0];
                    cnt_wdata        = w_inc;
                    n_res_v          = 1'b1;
                    n_res.status     = STS_COUNTED;
                    n_res.word_index = r_e[EIDX_W-1:0];
                    n_res.word_total = w_inc;
                    n_res.last       = 1'b1;
                    n_tlen           = '0;
                    n_hash           = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_INS: begin
                n_j = '0;
                if (w_full) begin
                    n_res_v      = 1'b1;
                    n_res.status = STS_FULL;
                    n_res.last   = 1'b1;
                    n_tlen       = '0;
                    n_hash       = '0;
                end else begin
                    wm_we  = 1'b1;
                    cnt_we = 1'b1;
                    hd_we  = 1'b1;
                end
            end
            S_CP_WR: begin
                wc_we = 1'b1;
                n_j   = r_j + 1'b1;
                if (w_jlast) begin
                    n_res_v          = 1'b1;
                    n_res.status     = STS_INSERTED;
                    n_res.word_index = r_eused[EIDX_W-1:0];
                    n_res.word_total = COUNT_W'(1);
                    n_res.last       = 1'b1;
                    n_eused          = r_eused + 1'b1;
                    n_tlen           = '0;
                    n_hash           = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_s    <= n_s;
        r_j    <= n_j;
        r_e    <= n_e;
        r_head <= n_head;
        r_next <= n_next;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
        r_res  <= n_res;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_tlen  <= '0;
            r_hash  <= '0;
            r_sused <= '0;
            r_sfill <= '0;
            r_eused <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_tlen  <= n_tlen;
            r_hash  <= n_hash;
            r_sused <= n_sused;
            r_sfill <= n_sfill;
            r_eused <= n_eused;
            r_res_v <= n_res_v;
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_v;

    wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD)) u_tok (
        .i_clk(i_clk), .i_we(tb_we), .i_waddr(tb_waddr), .i_wdata(tb_wdata),
        .i_raddr(tb_raddr), .o_rdata(tb_rdata)
    );

    wfc_ram #(.WIDTH(8), .DEPTH(STOP_WORDS * MAX_WORD)) u_stop_chars (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(r_cmd.ch),
        .i_raddr(sc_raddr), .o_rdata(sc_rdata)
    );

    wfc_ram #(.WIDTH(LEN_W), .DEPTH(STOP_WORDS)) u_stop_len (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(r_sused[SIDX_W-1:0]), .i_wdata(r_sfill),
        .i_raddr(sl_raddr), .o_rdata(sl_rdata)
    );

    wfc_ram #(.WIDTH(8), .DEPTH(ENTRIES * MAX_WORD)) u_word_chars (
        .i_clk(i_clk), .i_we(wc_we), .i_waddr(wc_waddr), .i_wdata(wc_wdata),
        .i_raddr(wc_raddr), .o_rdata(wc_rdata)
    );

    wfc_ram #(.WIDTH(LEN_W), .DEPTH(ENTRIES)) u_word_len (
        .i_clk(i_clk), .i_we(wm_we), .i_waddr(wm_waddr), .i_wdata(r_tlen),
        .i_raddr(wm_raddr), .o_rdata(wl_rdata)
    );

    wfc_ram #(.WIDTH(COUNT_W), .DEPTH(ENTRIES)) u_word_cnt (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(wm_raddr), .o_rdata(cnt_rdata)
    );

    wfc_ram #(.WIDTH(HEAD_W), .DEPTH(ENTRIES)) u_chain (
        .i_clk(i_clk), .i_we(wm_we), .i_waddr(wm_waddr), .i_wdata(r_head),
        .i_raddr(wm_raddr), .o_rdata(nx_rdata)
    );

    wfc_ram #(.WIDTH(HEAD_W), .DEPTH(HEADS)) u_heads (
        .i_clk(i_clk), .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(r_hash), .o_rdata(hd_rdata)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= LEN_W'(WORD_CAP))
        else $error("token length beyond word capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mod_done |-> (r_state == S_HASH))
        else $error("hash remainder arrived outside the hash wait");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eused <= ECNT_W'(ENTRIES))
        else $error("entry count beyond table size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sused <= SCNT_W'(STOP_WORDS))
        else $error("stop word count beyond store size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_res_v)
        else $error("result produced during bucket clearing");

endmodule

### sim/tb_word_frequency_counter_unit.sv
`timescale 1ns / 1ps

module tb_word_frequency_counter_unit;
    import wfc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 300;
    localparam logic [1:0] OP_BAD = 2'd3;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    t_item           i_item = '0;
    logic            i_cfg_we = 1'b0;
    logic [BC_W-1:0] i_cfg_wdata = '0;
    t_result         o_result;
    logic            o_result_valid;

    word_frequency_counter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_result      (o_result),
        .o_result_valid(o_result_valid)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the counter state.
    logic [7:0] word_text [ENTRIES][MAX_WORD];
    int         word_len [ENTRIES];
    int         word_cnt [ENTRIES];
    int         word_link [ENTRIES];
    int         heads [HEADS];
    int         entries_in_use;
    logic [7:0] stop_text [STOP_WORDS][MAX_WORD];
    int         stop_len [STOP_WORDS];
    int         stops_loaded;
    int         stop_pos;
    logic [7:0] token_text [MAX_WORD];
    int         token_len;
    int         token_hash;
    int         buckets = 1024;

    t_result pending_results[$];
    t_row    directed_rows[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      items_sent = 0;
    int      cycles = 0;
    bit      no_gaps = 0;

    function automatic t_result make_result(logic [3:0] st, int idx, int tot, int ch, bit lst);
        t_result r;
        r.status     = st;
        r.word_index = idx[9:0];
        r.word_total = tot[23:0];
        r.read_char  = ch[7:0];
        r.last       = lst;
        return r;
    endfunction

    function automatic t_item make_item(logic [1:0] op, int ch, bit tend, int ei);
        t_item it;
        it.operation   = op;
        it.char_code   = ch[7:0];
        it.token_end   = tend;
        it.entry_index = ei[9:0];
        return it;
    endfunction

    function automatic int hash_modulus();
        if (buckets == 0) return 1;
        if (buckets > HEADS) return HEADS;
        return buckets;
    endfunction

    function automatic bit token_is_stop();
        bit same;
        for (int s = 0; s < stops_loaded; s++) begin
            if (stop_len[s] == token_len) begin
                same = 1;
                for (int k = 0; k < token_len; k++)
                    if (stop_text[s][k] != token_text[k]) same = 0;
                if (same) return 1;
            end
        end
        return 0;
    endfunction

    function automatic t_result close_token();
        int  e;
        bit  same;
        if (token_len <= 1) return make_result(STS_SHORT, 0, 0, 0, 1);
        if (token_is_stop()) return make_result(STS_STOP, 0, 0, 0, 1);
        e = heads[token_hash];
        while (e != -1) begin
            if (word_len[e] == token_len) begin
                same = 1;
                for (int k = 0; k < token_len; k++)
                    if (word_text[e][k] != token_text[k]) same = 0;
                if (same) begin
                    if (word_cnt[e] < 24'hFFFFFF) word_cnt[e]++;
                    return make_result(STS_COUNTED, e, word_cnt[e], 0, 1);
                end
            end
            e = word_link[e];
        end
        if (entries_in_use >= ENTRIES) return make_result(STS_FULL, 0, 0, 0, 1);
        e = entries_in_use++;
        for (int k = 0; k < token_len; k++) word_text[e][k] = token_text[k];
        word_len[e]  = token_len;
        word_cnt[e]  = 1;
        word_link[e] = heads[token_hash];
        heads[token_hash] = e;
        return make_result(STS_INSERTED, e, 1, 0, 1);
    endfunction

    function automatic void predict_item(t_item it);
        int letter;
        bit room;
        int ei;
        case (it.operation)
            OP_TEXT: begin
                letter = 0;
                if (it.char_code >= "A" && it.char_code <= "Z") letter = it.char_code + 32;
                else if (it.char_code >= "a" && it.char_code <= "z") letter = it.char_code;
                if (letter != 0 && token_len < WORD_CAP) begin
                    token_text[token_len++] = letter[7:0];
                    token_hash = (256 * token_hash + letter) % hash_modulus();
                end
                if (it.token_end) begin
                    pending_results.push_back(close_token());
                    token_len  = 0;
                    token_hash = 0;
                end
            end
            OP_STOP: begin
                room = stops_loaded < STOP_WORDS;
                if (room && stop_pos < WORD_CAP) stop_text[stops_loaded][stop_pos++] = it.char_code;
                if (it.token_end) begin
                    if (room) begin
                        stop_len[stops_loaded++] = stop_pos;
                        pending_results.push_back(make_result(STS_STOP_LOAD, 0, 0, 0, 1));
                    end else begin
                        pending_results.push_back(make_result(STS_STOP_FULL, 0, 0, 0, 1));
                    end
                    stop_pos = 0;
                end
            end
            OP_READ: begin
                ei = it.entry_index;
                if (ei < entries_in_use) begin
                    for (int k = 0; k < word_len[ei]; k++)
                        pending_results.push_back(make_result(STS_READ, ei, word_cnt[ei],
                            word_text[ei][k], k + 1 == word_len[ei]));
                end else begin
                    pending_results.push_back(make_result(STS_INVALID, 0, 0, 0, 1));
                end
            end
            default: begin
                pending_results.push_back(make_result(STS_INVALID, 0, 0, 0, 1));
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_result_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (want != o_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, o_result);
                end
            end
        end
    end

    task automatic send_item(t_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_item(it);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_buckets(int value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[BC_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        buckets = value;
    endtask

    function automatic int noise_byte();
        int b;
        do b = $urandom_range(0, 255);
        while ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"));
        return b;
    endfunction

    task automatic send_sequence(logic [1:0] op, logic [7:0] bytes[$]);
        for (int k = 0; k < bytes.size(); k++)
            send_item(make_item(op, bytes[k], k == bytes.size() - 1, $urandom_range(0, 1023)));
    endtask

    task automatic send_word(string w, bit noisy);
        logic [7:0] bytes[$];
        for (int k = 0; k < w.len(); k++) begin
            if (noisy && $urandom_range(0, 4) == 0) bytes.push_back(8'(noise_byte()));
            bytes.push_back($urandom_range(0, 1) ? 8'(w[k] - 32) : 8'(w[k]));
        end
        if (noisy && $urandom_range(0, 2) == 0) bytes.push_back(8'(noise_byte()));
        send_sequence(OP_TEXT, bytes);
    endtask

    function automatic string random_letters(int n);
        string w = "";
        for (int k = 0; k < n; k++) w = {w, string'(8'($urandom_range("a", "z")))};
        return w;
    endfunction

    task automatic random_phase(int count);
        string vocab[8] = '{"the", "cat", "sat", "on", "mat", "hash", "counter", "ab"};
        logic [7:0] bytes[$];
        int pick;
        int target;
        no_gaps = 0;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) no_gaps = ~no_gaps;
            bytes = {};
            if (pick < 45) begin
                send_word(vocab[$urandom_range(0, 7)], 1);
            end else if (pick < 55) begin
                send_word(random_letters($urandom_range(2, 6)), 1);
            end else if (pick < 59) begin
                send_word(random_letters($urandom_range(56, 66)), 0);
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 3)) bytes.push_back(8'(noise_byte()));
                if ($urandom_range(0, 1)) bytes.push_back(8'($urandom_range("a", "z")));
                send_sequence(OP_TEXT, bytes);
            end else if (pick < 73) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    pick = $urandom_range(0, 7);
                    for (int k = 0; k < vocab[pick].len(); k++) bytes.push_back(vocab[pick][k]);
                end
                send_sequence(OP_STOP, bytes);
            end else if (pick < 75) begin
                repeat ($urandom_range(60, 64)) bytes.push_back(8'($urandom_range("a", "z")));
                send_sequence(OP_STOP, bytes);
            end else if (pick < 92 && entries_in_use > 0) begin
                send_item(make_item(OP_READ, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                    $urandom_range(0, entries_in_use - 1)));
            end else begin
                send_item(make_item($urandom_range(0, 1) ? OP_READ : OP_BAD,
                    $urandom_range(0, 255), 1'($urandom_range(0, 1)), $urandom_range(0, 1023)));
            end
        end
    endtask

    task automatic add_row(t_item it, bit typed, logic [3:0] st, int idx, int tot);
        t_row r;
        r.it    = it;
        r.typed = typed;
        r.res   = make_result(st, idx, tot, 0, 1);
        directed_rows.push_back(r);
    endtask

    initial begin
        for (int b = 0; b < HEADS; b++) heads[b] = -1;
        entries_in_use = 0;
        stops_loaded   = 0;
        stop_pos       = 0;
        token_len      = 0;
        token_hash     = 0;

        add_row(make_item(OP_READ, 0, 1, 0), 1, STS_INVALID, 0, 0);
        add_row(make_item(OP_BAD, 255, 1, 1023), 1, STS_INVALID, 0, 0);
        add_row(make_item(OP_TEXT, "A", 1, 1023), 1, STS_SHORT, 0, 0);
        add_row(make_item(OP_TEXT, "1", 1, 0), 1, STS_SHORT, 0, 0);
        add_row(make_item(OP_TEXT, "H", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "i", 1, 0), 1, STS_INSERTED, 0, 1);
        add_row(make_item(OP_TEXT, "h", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "I", 1, 0), 1, STS_COUNTED, 0, 2);
        add_row(make_item(OP_STOP, "t", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_STOP, "o", 1, 0), 1, STS_STOP_LOAD, 0, 0);
        add_row(make_item(OP_TEXT, "T", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "O", 1, 0), 1, STS_STOP, 0, 0);
        add_row(make_item(OP_STOP, "A", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_STOP, "X", 1, 0), 1, STS_STOP_LOAD, 0, 0);
        add_row(make_item(OP_TEXT, "a", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "x", 1, 0), 1, STS_INSERTED, 1, 1);
        add_row(make_item(OP_TEXT, 8'hFF, 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "z", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "{", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "@", 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_TEXT, "Z", 1, 0), 1, STS_INSERTED, 2, 1);
        add_row(make_item(OP_READ, 0, 0, 0), 0, 0, 0, 0);
        add_row(make_item(OP_READ, 0, 1, 2), 0, 0, 0, 0);
        add_row(make_item(OP_READ, 0, 1, 3), 1, STS_INVALID, 0, 0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_item(directed_rows[n].it);
            if (directed_rows[n].typed) begin
                void'(pending_results.pop_back());
                pending_results.push_back(directed_rows[n].res);
            end
        end

        write_buckets(1);
        random_phase(8);
        write_buckets(0);
        random_phase(8);
        write_buckets(2047);
        random_phase(8);
        write_buckets(37);
        random_phase(8);

        // Fill the stop-word store with one-letter stop words, then overflow it.
        drain();
        while (stops_loaded < STOP_WORDS)
            send_item(make_item(OP_STOP, $urandom_range("a", "z"), 1, 0));
        for (int k = 0; k < 2; k++)
            send_sequence(OP_STOP, '{"z", "q"});

        drain();
        $display("Sent %0d items and checked %0d results: %0d entries, %0d stop words.",
            items_sent, results_seen, entries_in_use, stops_loaded);
        $display("Bucket counts 1024, 1, 0, 2047 and 37; stop store filled and overrun.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### word_frequency_counter_unit.f
rtl/core/wfc_pkg.sv
rtl/core/wfc_ram.sv
rtl/core/wfc_front.sv
rtl/core/wfc_mod.sv
rtl/core/wfc_back.sv
rtl/core/word_frequency_counter_unit.sv
sim/tb_word_frequency_counter_unit.sv
